// ===== hdl/pdss_pkg.sv =====
package pdss_pkg;

	localparam int unsigned IDX_W  = 3;
	localparam int unsigned PRIO_W = 2;
	localparam int unsigned TIME_W = 32;

	localparam logic [1:0] ACT_REGISTER = 2'd0;
	localparam logic [1:0] ACT_POLL     = 2'd1;
	localparam logic [1:0] ACT_RESCHED  = 2'd2;

	localparam logic [1:0] KIND_NOP     = 2'd0;
	localparam logic [1:0] KIND_REG     = 2'd1;
	localparam logic [1:0] KIND_POLL    = 2'd2;
	localparam logic [1:0] KIND_RESCHED = 2'd3;

	localparam logic [TIME_W-1:0] IDLE_SLEEP_MS = 32'd1000;

	typedef struct packed {
		logic [1:0]        kind;
		logic [IDX_W-1:0]  slot;
		logic [PRIO_W-1:0] prio;
		logic [TIME_W-1:0] interval;
		logic [TIME_W-1:0] now;
	} cmd_t;

	function automatic logic wrap_before(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
		logic [TIME_W-1:0] d;
		d = a - b;
		return d[TIME_W-1];
	endfunction

endpackage

// ===== hdl/priority_deadline_slot_scheduler.sv =====
// Priority deadline slot scheduler.
// Commands enter on start/busy: an item is taken at a rising edge where start
// is high and busy is low. action selects register (0), poll (1) or
// reschedule (2); slot_index, priority_level, interval_ms and now_ms go with it.
// A front stage decodes the item into a two-entry queue; busy rises only when
// that stage holds an item and the queue is full.
// Every item gives exactly one result, shown for one cycle with strobe high on
// found, selected_slot and sleep_ms. The receiver cannot stall; results leave
// in item order.
// The back end runs one item at a time. Register and unknown actions finish
// in the execute state, a reschedule of an active slot adds a read-wait state,
// and a poll scans the slot memory, reading one slot per cycle, then passes
// a drain and a done state.
// Reset clears all active bits and the queue; slot data is valid only once a
// slot has been registered.
module priority_deadline_slot_scheduler import pdss_pkg::*; #(
	parameter int unsigned NUM_SLOTS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        action,
	input  logic [IDX_W-1:0]  slot_index,
	input  logic [PRIO_W-1:0] priority_level,
	input  logic [TIME_W-1:0] interval_ms,
	input  logic [TIME_W-1:0] now_ms,
	output logic              strobe,
	output logic              found,
	output logic [IDX_W-1:0]  selected_slot,
	output logic [TIME_W-1:0] sleep_ms
);

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	cmd_t q_wdata;
	cmd_t q_rdata;

	pdss_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.action         (action),
		.slot_index     (slot_index),
		.priority_level (priority_level),
		.interval_ms    (interval_ms),
		.now_ms         (now_ms),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_data         (q_wdata)
	);

	pdss_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	pdss_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_data        (q_rdata),
		.q_pop         (q_pop),
		.strobe        (strobe),
		.found         (found),
		.selected_slot (selected_slot),
		.sleep_ms      (sleep_ms)
	);

endmodule

// ===== hdl/pdss_front.sv =====
module pdss_front import pdss_pkg::*; #(
	parameter int unsigned NUM_SLOTS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        action,
	input  logic [IDX_W-1:0]  slot_index,
	input  logic [PRIO_W-1:0] priority_level,
	input  logic [TIME_W-1:0] interval_ms,
	input  logic [TIME_W-1:0] now_ms,
	input  logic              q_full,
	output logic              q_push,
	output cmd_t              q_data
);

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_d;
	logic in_range;
	logic accept;

	assign in_range = {{(32-IDX_W){1'b0}}, slot_index} < 32'(NUM_SLOTS);

	always_comb begin
		cmd_d.slot     = slot_index;
		cmd_d.prio     = priority_level;
		cmd_d.interval = interval_ms;
		cmd_d.now      = now_ms;
		unique case (action)
			ACT_REGISTER: cmd_d.kind = in_range ? KIND_REG : KIND_NOP;
			ACT_POLL:     cmd_d.kind = KIND_POLL;
			ACT_RESCHED:  cmd_d.kind = in_range ? KIND_RESCHED : KIND_NOP;
			default:      cmd_d.kind = KIND_NOP;
		endcase
	end

	assign busy   = valid_s1 && q_full;
	assign accept = start && !busy;
	assign q_push = valid_s1 && !q_full;
	assign q_data = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

// ===== hdl/pdss_queue.sv =====
module pdss_queue import pdss_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output cmd_t pop_data,
	output logic empty
);

	localparam int unsigned DEPTH = 2;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cmd_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = count_q == CNT_W'(DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== hdl/pdss_back.sv =====
module pdss_back import pdss_pkg::*; #(
	parameter int unsigned NUM_SLOTS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  cmd_t              q_data,
	output logic              q_pop,
	output logic              strobe,
	output logic              found,
	output logic [IDX_W-1:0]  selected_slot,
	output logic [TIME_W-1:0] sleep_ms
);

	localparam int unsigned AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EXEC   = 3'd1;
	localparam logic [2:0] ST_RDWAIT = 3'd2;
	localparam logic [2:0] ST_SCAN   = 3'd3;
	localparam logic [2:0] ST_DRAIN  = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	logic [2:0]           state_q;
	cmd_t                 cmd_q;
	logic [AW-1:0]        cnt_q;
	logic [NUM_SLOTS-1:0] active_q;

	logic [PRIO_W-1:0] prio_mem [NUM_SLOTS];
	logic [TIME_W-1:0] int_mem  [NUM_SLOTS];
	logic [TIME_W-1:0] due_mem  [NUM_SLOTS];

	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     cmd_addr;
	logic [PRIO_W-1:0] rd_prio_s1;
	logic [TIME_W-1:0] rd_int_s1;
	logic [TIME_W-1:0] rd_due_s1;
	logic              scan_v_s1;
	logic              act_s1;
	logic [AW-1:0]     idx_s1;

	logic              any_q;
	logic              have_q;
	logic [TIME_W-1:0] dl_q;
	logic [PRIO_W-1:0] best_prio_q;
	logic [TIME_W-1:0] best_due_q;
	logic [AW-1:0]     best_idx_q;

	logic              upd_dl;
	logic              upd_best;
	logic              is_due;
	logic [TIME_W-1:0] diff;

	logic              mem_we;
	logic [TIME_W-1:0] due_wdata;

	assign cmd_addr = AW'(cmd_q.slot);
	assign rd_addr  = (state_q == ST_SCAN) ? cnt_q : cmd_addr;
	assign q_pop    = (state_q == ST_IDLE) && !q_empty;

	assign is_due   = !wrap_before(cmd_q.now, rd_due_s1);
	assign upd_dl   = scan_v_s1 && act_s1 && (!any_q || wrap_before(rd_due_s1, dl_q));
	assign upd_best = scan_v_s1 && act_s1 && is_due &&
		(!have_q || rd_prio_s1 > best_prio_q ||
		 (rd_prio_s1 == best_prio_q && wrap_before(rd_due_s1, best_due_q)));

	assign diff = any_q ? (dl_q - cmd_q.now) : IDLE_SLEEP_MS;

	assign mem_we    = ((state_q == ST_EXEC) && (cmd_q.kind == KIND_REG)) ||
		(state_q == ST_RDWAIT);
	assign due_wdata = (state_q == ST_RDWAIT) ? (cmd_q.now + rd_int_s1) : cmd_q.now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			active_q  <= '0;
			strobe    <= 1'b0;
			scan_v_s1 <= 1'b0;
			any_q     <= 1'b0;
			have_q    <= 1'b0;
		end else begin
			strobe    <= 1'b0;
			scan_v_s1 <= state_q == ST_SCAN;
			if (upd_dl) begin
				any_q <= 1'b1;
			end
			if (upd_best) begin
				have_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					case (cmd_q.kind)
						KIND_REG: begin
							active_q[cmd_addr] <= 1'b1;
							strobe             <= 1'b1;
							state_q            <= ST_IDLE;
						end
						KIND_RESCHED: begin
							if (active_q[cmd_addr]) begin
								state_q <= ST_RDWAIT;
							end else begin
								strobe  <= 1'b1;
								state_q <= ST_IDLE;
							end
						end
						KIND_POLL: begin
							cnt_q   <= '0;
							any_q   <= 1'b0;
							have_q  <= 1'b0;
							state_q <= ST_SCAN;
						end
						default: begin
							strobe  <= 1'b1;
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_RDWAIT: begin
					strobe  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (cnt_q == AW'(NUM_SLOTS - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					strobe  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_data;
		end
		if (mem_we) begin
			due_mem[cmd_addr] <= due_wdata;
		end
		if ((state_q == ST_EXEC) && (cmd_q.kind == KIND_REG)) begin
			prio_mem[cmd_addr] <= cmd_q.prio;
			int_mem[cmd_addr]  <= cmd_q.interval;
		end
		rd_prio_s1 <= prio_mem[rd_addr];
		rd_int_s1  <= int_mem[rd_addr];
		rd_due_s1  <= due_mem[rd_addr];
		act_s1     <= active_q[cnt_q];
		idx_s1     <= cnt_q;
		if (upd_dl) begin
			dl_q <= rd_due_s1;
		end
		if (upd_best) begin
			best_prio_q <= rd_prio_s1;
			best_due_q  <= rd_due_s1;
			best_idx_q  <= idx_s1;
		end
		if (state_q == ST_DONE) begin
			found         <= have_q;
			selected_slot <= have_q ? IDX_W'(best_idx_q) : '0;
			sleep_ms      <= (!have_q && diff != '0 && !diff[TIME_W-1]) ? diff : '0;
		end else begin
			found         <= 1'b0;
			selected_slot <= '0;
			sleep_ms      <= '0;
		end
	end

	a_strobe_source: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ($past(state_q) == ST_EXEC || $past(state_q) == ST_RDWAIT ||
			$past(state_q) == ST_DONE))
		else $error("result strobe without a finishing state");

	a_found_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && found |-> sleep_ms == '0)
		else $error("found result carries a nonzero sleep time");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q == ST_EXEC)
		else $error("popped item not executed");

	a_scan_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> $past(state_q) == ST_SCAN && cnt_q == AW'(NUM_SLOTS - 1))
		else $error("poll scan ended early");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import pdss_pkg::*;

	localparam int unsigned SLOTS = 8;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam logic [1:0] ACT_NONE = 2'd3;

	typedef struct {
		logic [1:0]        action;
		logic [IDX_W-1:0]  slot;
		logic [PRIO_W-1:0] prio;
		logic [TIME_W-1:0] interval;
		logic [TIME_W-1:0] now;
		int unsigned       idle_pct;
	} sched_cmd_t;

	typedef struct {
		logic              found;
		logic [IDX_W-1:0]  slot;
		logic [TIME_W-1:0] sleep;
	} sched_answer_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [1:0]        action = ACT_POLL;
	logic [IDX_W-1:0]  slot_index = '0;
	logic [PRIO_W-1:0] priority_level = '0;
	logic [TIME_W-1:0] interval_ms = '0;
	logic [TIME_W-1:0] now_ms = '0;
	logic              strobe;
	logic              found;
	logic [IDX_W-1:0]  selected_slot;
	logic [TIME_W-1:0] sleep_ms;

	sched_cmd_t    pending_cmds[$];
	sched_cmd_t    in_flight;
	sched_answer_t outcome_q[$];

	logic              slot_on [SLOTS] = '{default: 1'b0};
	logic [PRIO_W-1:0] slot_prio [SLOTS];
	logic [TIME_W-1:0] slot_period [SLOTS];
	logic [TIME_W-1:0] slot_due [SLOTS];

	int unsigned errors = 0;
	int unsigned stall_cycles = 0;
	int unsigned results_seen = 0;
	int unsigned n_register = 0;
	int unsigned n_resched = 0;
	int unsigned n_poll = 0;
	int unsigned n_picked = 0;
	int unsigned n_noop = 0;

	priority_deadline_slot_scheduler #(.NUM_SLOTS(SLOTS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.slot_index(slot_index),
		.priority_level(priority_level),
		.interval_ms(interval_ms),
		.now_ms(now_ms),
		.strobe(strobe),
		.found(found),
		.selected_slot(selected_slot),
		.sleep_ms(sleep_ms)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic is_earlier(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
		logic [TIME_W-1:0] gap;
		gap = a - b;
		return $signed(gap) < 0;
	endfunction

	function automatic sched_answer_t schedule_outcome(sched_cmd_t c);
		sched_answer_t     ans;
		logic              any_on;
		logic              have;
		logic [PRIO_W-1:0] top_prio;
		logic [TIME_W-1:0] top_due;
		logic [TIME_W-1:0] earliest;
		logic [TIME_W-1:0] gap;
		logic [IDX_W-1:0]  top_idx;
		ans = '{1'b0, '0, '0};
		any_on = 1'b0;
		have = 1'b0;
		top_prio = '0;
		top_due = '0;
		earliest = '0;
		top_idx = '0;
		case (c.action)
			ACT_REGISTER: begin
				slot_on[c.slot] = 1'b1;
				slot_prio[c.slot] = c.prio;
				slot_period[c.slot] = c.interval;
				slot_due[c.slot] = c.now;
				n_register++;
			end
			ACT_RESCHED: begin
				if (slot_on[c.slot])
					slot_due[c.slot] = c.now + slot_period[c.slot];
				n_resched++;
			end
			ACT_POLL: begin
				n_poll++;
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_on[i]) begin
						if (!any_on || is_earlier(slot_due[i], earliest))
							earliest = slot_due[i];
						any_on = 1'b1;
						if (!is_earlier(c.now, slot_due[i]) && (!have
								|| slot_prio[i] > top_prio
								|| (slot_prio[i] == top_prio
								&& is_earlier(slot_due[i], top_due)))) begin
							have = 1'b1;
							top_prio = slot_prio[i];
							top_due = slot_due[i];
							top_idx = IDX_W'(i);
						end
					end
				end
				if (have) begin
					ans.found = 1'b1;
					ans.slot = top_idx;
					n_picked++;
				end else begin
					if (!any_on)
						earliest = c.now + IDLE_SLEEP_MS;
					gap = earliest - c.now;
					if (gap != '0 && !gap[TIME_W-1])
						ans.sleep = gap;
				end
			end
			default: begin
				n_noop++;
			end
		endcase
		return ans;
	endfunction

	task automatic queue_cmd(logic [1:0] act, logic [IDX_W-1:0] slot, logic [PRIO_W-1:0] prio,
			logic [TIME_W-1:0] interval, logic [TIME_W-1:0] now, int unsigned idle_pct);
		pending_cmds.push_back('{act, slot, prio, interval, now, idle_pct});
	endtask

	function automatic logic [TIME_W-1:0] pick_interval();
		case ($urandom_range(9))
			0: return '0;
			1: return $urandom;
			2: return 32'h8000_0000;
			3: return 32'hFFFF_FFFF;
			4: return 32'h7FFF_FFFF;
			default: return $urandom_range(40, 1);
		endcase
	endfunction

	task automatic compare_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				outcome_q.push_back(schedule_outcome(in_flight));
			if (!start || !busy) begin
				if (pending_cmds.size() != 0
						&& $urandom_range(99) >= pending_cmds[0].idle_pct) begin
					in_flight = pending_cmds.pop_front();
					action <= in_flight.action;
					slot_index <= in_flight.slot;
					priority_level <= in_flight.prio;
					interval_ms <= in_flight.interval;
					now_ms <= in_flight.now;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : watch_results
		sched_answer_t want;
		if (arst_n) begin
			if (strobe) begin
				results_seen++;
				if (outcome_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual found=%0b slot=%0d sleep=%0h",
						$time, found, selected_slot, sleep_ms);
				end else begin
					want = outcome_q.pop_front();
					compare_field("found", TIME_W'(want.found), TIME_W'(found));
					compare_field("selected_slot", TIME_W'(want.slot), TIME_W'(selected_slot));
					compare_field("sleep_ms", want.sleep, sleep_ms);
				end
			end
			if ((start && !busy) || strobe)
				stall_cycles = 0;
			else
				stall_cycles++;
		end
	end

	initial begin
		logic [TIME_W-1:0] clock_ms;
		int unsigned       counted;
		int unsigned       idle;
		int unsigned       pick;
		// Empty table, then a deadline exactly half the clock range ahead.
		queue_cmd(ACT_POLL, 3'd0, 2'd0, 32'h0, 32'h0, 0);
		queue_cmd(ACT_POLL, 3'd7, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		queue_cmd(ACT_RESCHED, 3'd3, 2'd0, 32'h0, 32'h5, 0);
		queue_cmd(ACT_NONE, 3'd7, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		queue_cmd(ACT_REGISTER, 3'd4, 2'd2, 32'h8000_0000, 32'h0, 0);
		queue_cmd(ACT_RESCHED, 3'd4, 2'd0, 32'h0, 32'h0, 0);
		queue_cmd(ACT_POLL, 3'd0, 2'd0, 32'h0, 32'h0, 0);
		queue_cmd(ACT_REGISTER, 3'd0, 2'd0, 32'h0, 32'd100, 0);
		queue_cmd(ACT_POLL, 3'd0, 2'd0, 32'h0, 32'd100, 0);
		queue_cmd(ACT_RESCHED, 3'd0, 2'd0, 32'h0, 32'd200, 0);
		queue_cmd(ACT_POLL, 3'd0, 2'd0, 32'h0, 32'd199, 0);
		queue_cmd(ACT_REGISTER, 3'd7, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 0);
		queue_cmd(ACT_POLL, 3'd0, 2'd0, 32'h0, 32'hFFFF_FFF0, 0);
		queue_cmd(ACT_RESCHED, 3'd7, 2'd0, 32'h0, 32'hFFFF_FFF0, 0);
		queue_cmd(ACT_REGISTER, 3'd5, 2'd3, 32'h8000_0000, 32'h10, 0);
		queue_cmd(ACT_REGISTER, 3'd2, 2'd3, 32'd7, 32'h10, 0);
		queue_cmd(ACT_POLL, 3'd0, 2'd0, 32'h0, 32'h10, 0);
		queue_cmd(ACT_REGISTER, 3'd7, 2'd1, 32'd3, 32'h1000, 0);
		queue_cmd(ACT_POLL, 3'd0, 2'd0, 32'h0, 32'h10, 0);
		queue_cmd(ACT_RESCHED, 3'd2, 2'd0, 32'h0, 32'h10, 0);
		queue_cmd(ACT_RESCHED, 3'd5, 2'd0, 32'h0, 32'h10, 0);
		queue_cmd(ACT_POLL, 3'd0, 2'd0, 32'h0, 32'h10, 0);
		queue_cmd(ACT_REGISTER, 3'd2, 2'd3, 32'h0, 32'h10, 0);
		queue_cmd(ACT_POLL, 3'd0, 2'd0, 32'h0, 32'h10, 0);

		for (int phase = 0; phase < 4; phase++) begin
			clock_ms = ($urandom_range(3) == 0) ? 32'hFFFF_FF00 + $urandom_range(255) : $urandom;
			counted = 0;
			while (counted < 130) begin
				case (phase)
					1: idle = 70;
					3: idle = 11;
					default: idle = 0;
				endcase
				if (counted >= 60 && counted < 80)
					idle = 0;
				pick = $urandom_range(99);
				if (pick < 80)
					clock_ms = clock_ms + $urandom_range(15);
				else if (pick < 95)
					clock_ms = clock_ms;
				else
					clock_ms = $urandom;
				pick = $urandom_range(99);
				if (pick < 20)
					queue_cmd(ACT_REGISTER, IDX_W'($urandom), PRIO_W'($urandom),
						pick_interval(), clock_ms, idle);
				else if (pick < 45)
					queue_cmd(ACT_RESCHED, IDX_W'($urandom), PRIO_W'($urandom), $urandom,
						clock_ms, idle);
				else if (pick < 95)
					queue_cmd(ACT_POLL, IDX_W'($urandom), PRIO_W'($urandom), $urandom,
						clock_ms, idle);
				else
					queue_cmd(ACT_NONE, IDX_W'($urandom), PRIO_W'($urandom), $urandom,
						$urandom, idle);
				if (pick < 95)
					counted++;
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while ((pending_cmds.size() != 0 || start || outcome_q.size() != 0)
				&& stall_cycles < STALL_LIMIT)
			@(posedge clk);
		if (stall_cycles >= STALL_LIMIT)
			$display("%0t: timeout, no handshake for %0d cycles", $time, STALL_LIMIT);
		else
			repeat (20) @(posedge clk);
		if (outcome_q.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived", $time, outcome_q.size());
		end

		$display("Sent %0d register, %0d reschedule, %0d poll and %0d no-op items; %0d results.",
			n_register, n_resched, n_poll, n_noop, results_seen);
		$display("%0d polls picked a slot, %0d reported a sleep time; %0d mismatches.",
			n_picked, n_poll - n_picked, errors);
		if (errors == 0 && stall_cycles < STALL_LIMIT)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
